FILE: src/lis_pkg.sv
// lis_pkg: shared constants and the token type for the smallest-tail search chain
// used by lis_cell and lis_length_tails_search_core; no dependencies

package lis_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int VALUE_W   = 32;
    localparam int RES_LEN_W = 11;
    localparam int RES_MAX   = (1 << RES_LEN_W) - 1;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      done;
        logic                      ext;
    } t_token;

endpackage

FILE: src/lis_cell.sv
// lis_cell: one tail slot of the search chain; takes a token from its left neighbor,
// stores, replaces or passes the value, and hands the token right; uses lis_pkg

module lis_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  lis_pkg::t_token i_tok,
    output lis_pkg::t_token o_tok
);

    logic signed [lis_pkg::VALUE_W-1:0] r_tail;
    logic signed [lis_pkg::VALUE_W-1:0] n_tail;
    logic                               r_full;
    logic                               n_full;
    lis_pkg::t_token                    r_tok;
    lis_pkg::t_token                    n_tok;

    always_comb begin
        n_tail = r_tail;
        n_full = r_full;
        n_tok  = i_tok;
        if (i_tok.valid && !i_tok.done) begin
            if (!r_full) begin
                n_tail    = i_tok.value;
                n_full    = 1'b1;
                n_tok.done = 1'b1;
                n_tok.ext  = 1'b1;
            end else if (r_tail >= i_tok.value) begin
                n_tail     = i_tok.value;
                n_tok.done = 1'b1;
            end
        end
        // end of sequence empties the slot for the next one
        if (i_tok.valid && i_tok.last) begin
            n_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full      <= 1'b0;
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_full <= n_full;
            r_tok  <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tail <= n_tail;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: src/lis_length_tails_search_core.sv
// lis_length_tails_search_core: streaming longest strictly increasing subsequence length
// built as a row of lis_cell tail slots followed by a length counter; uses lis_pkg
//
// usage:
//   input stream: i_s_tdata carries one signed 32-bit element, i_s_tlast marks the final
//   element of a sequence. output stream: one transaction per input transaction, in order,
//   o_m_tdata carries the length so far, o_m_tlast echoes the input last flag and
//   o_m_tuser flags a refused extension on a full table within the sequence.
//   every element enters cell 0 and moves one cell per cycle, unless the row holds, through MAX_LEN
//   cells; the first empty cell or first tail greater or equal takes it, then it rides on to the end.
//   throughput is one element per cycle while the row is not held; a new element may follow before the last leaves.
//   a last element empties each cell as it passes, so the next sequence can follow at once.
//   reset empties all cells and clears the counter and the overflow flag.
//   when the receiver stalls with a result waiting, the whole row holds and o_s_tready
//   drops until that result is taken.

module lis_length_tails_search_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic        i_s_tlast,   // last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [10:0] lis_length, [15:11] zero
    output logic        o_m_tlast,   // final_res
    output logic        o_m_tuser    // overflow
);

    lis_pkg::t_token w_tok [lis_pkg::MAX_LEN+1];

    logic                            w_en;
    logic                            r_out_valid;
    logic [lis_pkg::RES_LEN_W-1:0]   r_res_len;
    logic                            r_res_last;
    logic                            r_res_ovf;
    logic [lis_pkg::LEN_W-1:0]       r_len;
    logic [lis_pkg::LEN_W-1:0]       n_len;
    logic                            r_ovf;
    logic                            n_ovf;
    logic [lis_pkg::RES_LEN_W-1:0]   w_shown;
    lis_pkg::t_token                 w_exit;

    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    // valid, value, last, done, ext
    assign w_tok[0] = {i_s_tvalid, i_s_tdata, i_s_tlast, 1'b0, 1'b0};

    for (genvar g = 0; g < lis_pkg::MAX_LEN; g++) begin : g_cell
        lis_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_exit = w_tok[lis_pkg::MAX_LEN];

    always_comb begin
        n_len = r_len + lis_pkg::LEN_W'(w_exit.ext);
        // a token that found no slot was refused on a full table
        n_ovf = r_ovf | !w_exit.done;
        if (32'(n_len) > 32'(lis_pkg::RES_MAX)) begin
            w_shown = lis_pkg::RES_LEN_W'(lis_pkg::RES_MAX);
        end else begin
            w_shown = lis_pkg::RES_LEN_W'(n_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_len       <= '0;
            r_ovf       <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_exit.valid;
            if (w_exit.valid) begin
                if (w_exit.last) begin
                    r_len <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_len <= n_len;
                    r_ovf <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_exit.valid) begin
            r_res_len  <= w_shown;
            r_res_last <= w_exit.last;
            r_res_ovf  <= n_ovf;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(16 - lis_pkg::RES_LEN_W)'(0), r_res_len};
    assign o_m_tlast  = r_res_last;
    assign o_m_tuser  = r_res_ovf;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len) <= lis_pkg::MAX_LEN)
        else $error("length counter beyond table size");

    a_ext_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exit.valid && w_exit.ext) |-> (32'(r_len) < lis_pkg::MAX_LEN))
        else $error("extension reached a full table");

    a_ext_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exit.valid && w_exit.ext) |-> w_exit.done)
        else $error("extended token not marked done");

    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_exit.valid && w_exit.last) |=> (r_len == '0 && !r_ovf))
        else $error("sequence state not cleared after last");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_len)))
        else $error("state moved while output stalled");

endmodule

FILE: tb/lis_length_check.sv
// lis_length_check: watches both streams of lis_length_tails_search_core, tracks the
// smallest-tail table on its own and compares every output transaction in order
// depends on lis_pkg for sizes

module lis_length_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic        i_s_tlast,   // last
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [10:0] lis_length, [15:11] zero
    input  logic        i_m_tlast,   // final_res
    input  logic        i_m_tuser,   // overflow
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [lis_pkg::RES_LEN_W-1:0] length;
        logic                          fin;
        logic                          ovf;
    } t_lis_result;

    logic signed [lis_pkg::VALUE_W-1:0] tails [lis_pkg::MAX_LEN];
    int          run_len  = 0;
    bit          ovf_seen = 1'b0;
    t_lis_result lengths_due [$];
    t_lis_result due_now;
    int          fail_total = 0;
    int          due_count  = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = due_count;

    task automatic report_mismatch(input string what, input int want, input int got);
        fail_total++;
        if (fail_total <= 100)
            $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
    endtask

    // place one element into the tail table and return the length it leaves
    function automatic t_lis_result advance_tails(input logic signed [31:0] v,
                                                  input logic fin);
        int          slot;
        t_lis_result r;
        slot = run_len;
        for (int k = 0; k < run_len; k++)
            if (slot == run_len && tails[k] >= v)
                slot = k;
        if (slot < run_len)
            tails[slot] = v;
        else if (run_len < lis_pkg::MAX_LEN) begin
            tails[run_len] = v;
            run_len++;
        end else
            ovf_seen = 1'b1;
        r.length = lis_pkg::RES_LEN_W'((run_len > lis_pkg::RES_MAX) ? lis_pkg::RES_MAX
                                                                     : run_len);
        r.fin    = fin;
        r.ovf    = ovf_seen;
        if (fin) begin
            run_len  = 0;
            ovf_seen = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_len  = 0;
            ovf_seen = 1'b0;
            lengths_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                lengths_due.push_back(advance_tails($signed(i_s_tdata), i_s_tlast));
            if (i_m_tvalid && i_m_tready) begin
                if (lengths_due.size() == 0)
                    report_mismatch("unexpected transaction, length", -1, int'(i_m_tdata));
                else begin
                    due_now = lengths_due.pop_front();
                    if (i_m_tdata !== 16'(due_now.length))
                        report_mismatch("length", int'(due_now.length), int'(i_m_tdata));
                    if (i_m_tlast !== due_now.fin)
                        report_mismatch("final flag", int'(due_now.fin), int'(i_m_tlast));
                    if (i_m_tuser !== due_now.ovf)
                        report_mismatch("overflow", int'(due_now.ovf), int'(i_m_tuser));
                end
            end
        end
        due_count <= lengths_due.size();
    end

endmodule

FILE: tb/tb_lis_length_tails_search_core.sv
// tb_lis_length_tails_search_core: drives sequences into lis_length_tails_search_core
// with bursty input and a stalling receiver; lis_length_check does the comparing
// depends on lis_pkg, lis_length_check and the core

module tb_lis_length_tails_search_core;

    localparam int ITEM_GOAL = 1450;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_COMB} t_rx_mode;
    typedef enum int {SH_WIDE, SH_NARROW, SH_RISING, SH_FALLING, SH_EDGE} t_shape;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    int       fail_count;
    int       pending;
    int       items_sent = 0;
    int       burst_left = 0;
    bit       tx_steady  = 1'b0;
    bit       rx_hold    = 1'b0;
    t_rx_mode rx_mode    = RX_OPEN;
    int       rx_left    = 0;
    int       rx_phase   = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    lis_length_tails_search_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    lis_length_check u_lis_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver stall pattern, switched to a random mode when its countdown runs out
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(40, 400);
        end else
            rx_left <= rx_left - 1;
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            RX_OPEN:  m_tready <= !rx_hold;
            RX_LIGHT: m_tready <= !rx_hold && ($urandom_range(0, 7) != 0);
            RX_HEAVY: m_tready <= !rx_hold && ($urandom_range(0, 1) == 1);
            default:  m_tready <= !rx_hold && (rx_phase % 3 != 0);
        endcase
    end

    // long receiver hold-off so the cell row fills and input backs up
    initial begin
        while (items_sent < 5) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (2 * lis_pkg::MAX_LEN + 200) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_elem(input logic signed [31:0] v, input logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = tx_steady ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= $urandom;
                s_tlast  <= 1'($urandom_range(0, 1));
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    function automatic logic signed [31:0] pick_value(input t_shape sh,
                                                      input logic signed [31:0] prev);
        case (sh)
            SH_NARROW:  return $signed($urandom_range(0, 8)) - 4;
            SH_RISING:  return prev + $urandom_range(0, 1000);
            SH_FALLING: return prev - $urandom_range(0, 1000);
            SH_EDGE: begin
                case ($urandom_range(0, 6))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh8000_0001;
                    2:       return -1;
                    3:       return 0;
                    4:       return 1;
                    5:       return 32'sh7fff_fffe;
                    default: return 32'sh7fff_ffff;
                endcase
            end
            default:    return $urandom;
        endcase
    endfunction

    initial begin
        logic signed [31:0] cur;
        longint             ramp;
        t_shape             sh;
        int                 n;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-element sequences at both extremes
        send_elem(32'sh8000_0000, 1'b1);
        send_elem(32'sh7fff_ffff, 1'b1);
        // equal values replace, never extend
        send_elem(0, 1'b0);
        send_elem(0, 1'b0);
        send_elem(-1, 1'b0);
        send_elem(1, 1'b0);
        send_elem(1, 1'b0);
        send_elem(32'sh8000_0000, 1'b0);
        send_elem(32'sh7fff_ffff, 1'b0);
        send_elem(32'sh7fff_ffff, 1'b0);
        send_elem(2, 1'b0);
        send_elem(3, 1'b1);
        // strictly falling
        send_elem(100, 1'b0);
        send_elem(50, 1'b0);
        send_elem(0, 1'b0);
        send_elem(-50, 1'b0);
        send_elem(-100, 1'b1);
        // interleaved
        send_elem(5, 1'b0);
        send_elem(1, 1'b0);
        send_elem(6, 1'b0);
        send_elem(2, 1'b0);
        send_elem(7, 1'b1);

        // fill the table exactly, then refuse two extensions, replace, end on a refusal
        ramp = -64'sd2147483648;
        for (int k = 0; k < lis_pkg::MAX_LEN + 2; k++) begin
            send_elem(ramp[31:0], 1'b0);
            ramp = ramp + $urandom_range(1, 2_000_000);
        end
        send_elem(32'sh8000_0000, 1'b0);
        send_elem(32'sh7fff_ffff, 1'b1);

        while (items_sent < ITEM_GOAL) begin
            sh = t_shape'($urandom_range(0, 4));
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
            tx_steady = ($urandom_range(0, 3) == 0);
            cur = $urandom;
            for (int k = 0; k < n; k++) begin
                cur = pick_value(sh, cur);
                send_elem(cur, k == n - 1);
            end
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (lis_pkg::MAX_LEN + 64) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
